/* src/cltr_pkg.sv */
`default_nettype none
package cltr_pkg;

  localparam int COORD_WIDTH = 24;
  localparam int HOURS_WIDTH = 21;
  localparam int DEF_STAGES  = 18;
  localparam int MIN_STAGES  = 8;
  localparam int MAX_STAGES  = 24;

  // datapath carries extra fraction bits plus headroom for CORDIC growth
  localparam int GUARD   = 34 - COORD_WIDTH;
  localparam int WORK_W  = COORD_WIDTH + GUARD + 4;
  localparam int ANGLE_W = 32;
  localparam int GAIN_W  = 30;

  localparam logic [ANGLE_W-1:0]     HALF_TURN = 32'h8000_0000;
  localparam logic [HOURS_WIDTH-1:0] FULL_DAY  = 21'd1572864;
  localparam logic [HOURS_WIDTH-1:0] HALF_DAY  = 21'd786432;

  localparam logic [ANGLE_W-1:0] ATAN_TURNS [0:MAX_STAGES-1] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x_coord;
    logic signed [COORD_WIDTH-1:0] y_coord;
    logic                          last_in;
  } in_t;

  typedef struct packed {
    logic [COORD_WIDTH-1:0] radius;
    logic [HOURS_WIDTH-1:0] local_time_hours;
    logic                   last_out;
  } out_t;

  typedef struct packed {
    logic                     valid;
    logic                     last;
    logic                     zero;
    logic signed [WORK_W-1:0] u;
    logic signed [WORK_W-1:0] v;
    logic [ANGLE_W-1:0]       angle;
  } stage_t;

  // Q30 gain compensation for a given stage count
  function automatic logic [GAIN_W-1:0] gain_q30(input int n);
    logic [GAIN_W-1:0] g;
    case (n)
      8:       g = 30'd652039507;
      9:       g = 30'd652034532;
      10:      g = 30'd652033289;
      11:      g = 30'd652032978;
      12:      g = 30'd652032900;
      13:      g = 30'd652032880;
      14:      g = 30'd652032876;
      default: g = 30'd652032874;
    endcase
    return g;
  endfunction

endpackage
`default_nettype wire

/* src/cltr_cell.sv */
`default_nettype none
module cltr_cell
  import cltr_pkg::*;
#(
  parameter int STAGE = 0
) (
  input  wire    clk,
  input  wire    rst_n,
  input  stage_t s_in,
  output stage_t s_out
);

  stage_t s_r, s_nxt;
  logic signed [WORK_W-1:0] u, v, u_sh, v_sh;

  assign u    = s_in.u;
  assign v    = s_in.v;
  assign u_sh = u >>> STAGE;
  assign v_sh = v >>> STAGE;

  // rotate toward the x axis, steering by the sign of v
  always_comb begin
    s_nxt = s_in;
    if (!v[WORK_W-1]) begin
      s_nxt.u     = u + v_sh;
      s_nxt.v     = v - u_sh;
      s_nxt.angle = s_in.angle + ATAN_TURNS[STAGE];
    end else begin
      s_nxt.u     = u - v_sh;
      s_nxt.v     = v + u_sh;
      s_nxt.angle = s_in.angle - ATAN_TURNS[STAGE];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r.valid <= 1'b0;
    end else begin
      s_r <= s_nxt;
    end
  end

  assign s_out = s_r;

endmodule
`default_nettype wire

/* src/cltr_post.sv */
`default_nettype none
module cltr_post
  import cltr_pkg::*;
#(
  parameter int NSTG = DEF_STAGES
) (
  input  wire    clk,
  input  wire    rst_n,
  input  stage_t s_in,
  output logic   out_valid,
  output out_t   out_data
);

  localparam int UW     = WORK_W - 1;
  localparam int LO_W   = 18;
  localparam int HI_W   = UW - LO_W;
  localparam int SUM_W  = UW + GAIN_W + 1;
  localparam int RSH    = 30 + GUARD;
  localparam int RFULLW = SUM_W - RSH;
  localparam int H3_W   = ANGLE_W + 2;
  localparam logic [GAIN_W-1:0] GAIN  = gain_q30(NSTG);
  localparam logic [SUM_W-1:0]  ROUND = SUM_W'(1) << (RSH - 1);
  localparam logic [H3_W-1:0]   H_RND = H3_W'(4096);

  logic [UW-1:0]          u_mag;
  logic [H3_W-1:0]        h3;
  logic [HOURS_WIDTH-1:0] h_raw, h_nxt;

  logic                     valid_a_r, last_a_r, zero_a_r;
  logic [LO_W+GAIN_W-1:0]   p_lo_r;
  logic [HI_W+GAIN_W-1:0]   p_hi_r;
  logic [HOURS_WIDTH-1:0]   hours_a_r;

  logic [SUM_W-1:0]       sum;
  logic [RFULLW-1:0]      r_full;
  logic [COORD_WIDTH-1:0] r_sat;
  out_t                   out_nxt, out_r;
  logic                   out_valid_r;

  // clamp negative residue to zero
  assign u_mag = s_in.u[WORK_W-1] ? '0 : s_in.u[UW-1:0];

  // angle * 24 / 2^32 with 16 fraction bits, rounded half up
  assign h3    = {2'b00, s_in.angle} + {1'b0, s_in.angle, 1'b0} + H_RND;
  assign h_raw = h3[H3_W-1:13];
  assign h_nxt = (h_raw >= FULL_DAY) ? h_raw - FULL_DAY : h_raw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
    end else begin
      valid_a_r <= s_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    last_a_r  <= s_in.last;
    zero_a_r  <= s_in.zero;
    p_lo_r    <= u_mag[LO_W-1:0] * GAIN;
    p_hi_r    <= u_mag[UW-1:LO_W] * GAIN;
    hours_a_r <= h_nxt;
  end

  assign sum    = (SUM_W'(p_hi_r) << LO_W) + SUM_W'(p_lo_r) + ROUND;
  assign r_full = sum[SUM_W-1:RSH];
  assign r_sat  = ((r_full >> COORD_WIDTH) != '0) ? '1 : r_full[COORD_WIDTH-1:0];

  always_comb begin
    out_nxt.last_out = last_a_r;
    if (zero_a_r) begin
      out_nxt.radius           = '0;
      out_nxt.local_time_hours = HALF_DAY;
    end else begin
      out_nxt.radius           = r_sat;
      out_nxt.local_time_hours = hours_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= valid_a_r;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

/* src/cartesian_to_local_time_radius_core.sv */
`default_nettype none
// Pipeline from start to out_valid: one entry stage, one cell per CORDIC iteration,
// then two stages for gain and hours.
// Throughput: one item per cycle; busy is always low since every stage advances each cycle.
// Results come on a one-cycle out_valid strobe; the receiver cannot stall.
// Reset (synchronous, rst_n low) clears all valid flags; items in flight are dropped.
module cartesian_to_local_time_radius_core
  import cltr_pkg::*;
#(
  parameter int CORDIC_STAGES = DEF_STAGES
) (
  input  wire  clk,
  input  wire  rst_n,
  input  wire  start,
  output logic busy,
  input  in_t  in_data,
  output logic out_valid,
  output out_t out_data
);

  localparam int NSTG = (CORDIC_STAGES < MIN_STAGES) ? MIN_STAGES :
                        (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;
  localparam int LATENCY = NSTG + 3;

  stage_t chain [0:NSTG];
  stage_t ent_r, ent_nxt;
  logic signed [WORK_W-1:0] x_ext, y_ext, u0, v0;

  assign busy = 1'b0;

  assign x_ext = WORK_W'(in_data.x_coord) <<< GUARD;
  assign y_ext = WORK_W'(in_data.y_coord) <<< GUARD;
  assign u0    = -x_ext;
  assign v0    = -y_ext;

  // turn by 180 degrees, then fold the left half plane back onto the right
  always_comb begin
    ent_nxt.valid = start & ~busy;
    ent_nxt.last  = in_data.last_in;
    ent_nxt.zero  = (in_data.x_coord == '0) && (in_data.y_coord == '0);
    if (u0[WORK_W-1]) begin
      ent_nxt.u     = x_ext;
      ent_nxt.v     = y_ext;
      ent_nxt.angle = HALF_TURN;
    end else begin
      ent_nxt.u     = u0;
      ent_nxt.v     = v0;
      ent_nxt.angle = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.valid <= 1'b0;
    end else begin
      ent_r <= ent_nxt;
    end
  end

  assign chain[0] = ent_r;

  for (genvar i = 0; i < NSTG; i++) begin : g_cell
    cltr_cell #(
      .STAGE(i)
    ) u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .s_in (chain[i]),
      .s_out(chain[i+1])
    );
  end

  cltr_post #(
    .NSTG(NSTG)
  ) u_post (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_in     (chain[NSTG]),
    .out_valid(out_valid),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

/* src/cltr_checker.sv */
`default_nettype none
module cltr_checker
  import cltr_pkg::*;
#(
  parameter int LATENCY = DEF_STAGES + 3
) (
  input wire  clk,
  input wire  rst_n,
  input wire  start,
  input wire  busy,
  input in_t  in_data,
  input wire  out_valid,
  input out_t out_data
);

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_result_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LATENCY))
    else $error("result without an item accepted LATENCY cycles earlier");

  a_last_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.last_out == $past(in_data.last_in, LATENCY))
    else $error("last flag does not match its item");

  a_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(in_data.x_coord == '0 && in_data.y_coord == '0, LATENCY)
      |-> out_data.radius == '0 && out_data.local_time_hours == HALF_DAY)
    else $error("origin item gave wrong result");

  a_hours_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.local_time_hours < FULL_DAY)
    else $error("local time out of range");

endmodule

bind cartesian_to_local_time_radius_core cltr_checker #(
  .LATENCY(LATENCY)
) u_cltr_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_data (out_data)
);
`default_nettype wire
